/* hdl/rud_pkg.sv */
// Shared package for the radial undistortion core.
// Holds default sizes, field widths, register indexes and the front-to-back job type.
// No dependencies.
`timescale 1ns / 1ps

package rud_pkg;

    // Default sizes handed to the top-level parameters
    localparam int DEF_MAX_WIDTH  = 512;
    localparam int DEF_MAX_HEIGHT = 512;
    localparam int DEF_FRAC_BITS  = 8;
    localparam int DEF_QDEPTH     = 16;

    // Fixed field widths
    localparam int POS_W      = 9;
    localparam int CH_W       = 8;
    localparam int PIX_W      = 24;
    localparam int COORD_W    = 10;
    localparam int FRAC_MAX   = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 40;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INVF   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_K1     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_K2     = 3'd4;

    // Action codes
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_REQ  = 1'b1;

    // Classified job passed from the front part to the back part.
    // Load: ok = inside the store, x/y = position, rgb = pixel.
    // Request: ok = source inside the image, x/y = integer source, fx/fy = fraction.
    typedef struct packed {
        logic                req;
        logic                ok;
        logic [COORD_W-1:0]  x;
        logic [COORD_W-1:0]  y;
        logic [PIX_W-1:0]    rgb;
        logic [FRAC_MAX-1:0] fx;
        logic [FRAC_MAX-1:0] fy;
    } t_job;

endpackage

/* hdl/rud_if.sv */
// Channel interfaces of the radial undistortion core: pixel in, pixel out, config write.
// Depends on rud_pkg.
`timescale 1ns / 1ps

interface rud_in_if import rud_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             action;
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] row_pos;
    logic [CH_W-1:0]  red_in;
    logic [CH_W-1:0]  green_in;
    logic [CH_W-1:0]  blue_in;

    modport source (output valid, action, col, row_pos, red_in, green_in, blue_in,
                    input ready);
    modport sink   (input valid, action, col, row_pos, red_in, green_in, blue_in,
                    output ready);
endinterface

interface rud_out_if import rud_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] red_out;
    logic [CH_W-1:0] green_out;
    logic [CH_W-1:0] blue_out;
    logic            sampled;

    modport source (output valid, red_out, green_out, blue_out, sampled, input ready);
    modport sink   (input valid, red_out, green_out, blue_out, sampled, output ready);
endinterface

interface rud_cfg_if import rud_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* hdl/rud_front.sv */
// Front part: config registers, transaction intake and the coordinate mapping pipeline.
// Emits one classified job per accepted transaction. Depends on rud_pkg, rud_if.
`timescale 1ns / 1ps

module rud_front import rud_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int FRAC_BITS  = DEF_FRAC_BITS,
    parameter int QDEPTH     = DEF_QDEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rud_in_if.sink     i_pix,
    rud_cfg_if.sink    i_cfg,
    output logic       o_push,
    output t_job       o_job,
    input  logic       i_pop
);

    localparam int NST   = 13;
    localparam int CNT_W = $clog2(QDEPTH + 1);
    localparam int PXW   = 23 + FRAC_BITS;

    typedef struct packed {
        logic               req;
        logic               ok;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [PIX_W-1:0]   rgb;
    } t_tag;

    // Config registers
    logic [COORD_W-1:0]    r_img_w, r_img_h;
    logic [CFG_DATA_W-1:0] r_inv;
    logic signed [31:0]    r_k1, r_k2;
    logic [COORD_W-1:0]    r_w, r_h;

    // Credit count: transactions in the pipeline plus the queue
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             acc;

    // Pipeline registers
    logic [NST-1:0]     r_vld;
    t_tag               r_tag [NST];
    logic signed [11:0] r_xc [10];
    logic signed [11:0] r_yc [10];
    logic [20:0]        r_sqx, r_sqy, r_s;
    logic [40:0]        r_plo, r_phi;
    logic [29:0]        r_r2;
    logic [59:0]        r_r2sq_f;
    logic [62:0]        r_t1;
    logic [31:0]        r_r2sq;
    logic [35:0]        r_k1t, r_k1t7, r_k1t8;
    logic [64:0]        r_t2;
    logic [37:0]        r_k2t;
    logic signed [38:0] r_fac;
    logic signed [50:0] r_mx, r_my;
    logic [PXW-1:0]     r_px, r_py;
    t_job               r_job;

    logic signed [11:0] n_xc, n_yc;
    logic signed [23:0] n_sqx, n_sqy;
    logic [61:0]        n_sum;
    logic [47:0]        n_q;
    logic [60:0]        n_sq;
    logic [63:0]        n_k1r;
    logic [65:0]        n_k2r;
    logic [38:0]        n_fac;
    logic [51:0]        n_sx, n_sy;
    logic [COORD_W+FRAC_BITS-1:0] lim_x, lim_y;
    logic               n_inside;
    t_job               n_job;
    t_tag               n_tag;

    assign acc         = i_pix.valid && i_pix.ready;
    assign i_pix.ready = (r_cnt < CNT_W'(QDEPTH));
    assign i_cfg.ready = 1'b1;

    always_comb begin
        n_cnt = r_cnt;
        if (acc && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!acc && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    // Config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w <= COORD_W'(512);
            r_img_h <= COORD_W'(512);
            r_inv   <= '0;
            r_k1    <= '0;
            r_k2    <= '0;
            r_cnt   <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    CFG_WIDTH:  r_img_w <= i_cfg.data[COORD_W-1:0];
                    CFG_HEIGHT: r_img_h <= i_cfg.data[COORD_W-1:0];
                    CFG_INVF:   r_inv   <= i_cfg.data;
                    CFG_K1:     r_k1    <= i_cfg.data[31:0];
                    CFG_K2:     r_k2    <= i_cfg.data[31:0];
                    default:    ;
                endcase
            end
        end
    end

    // Clamped image size
    always_ff @(posedge i_clk) begin
        if (r_img_w < COORD_W'(2)) begin
            r_w <= COORD_W'(2);
        end else if ({3'b0, r_img_w} > 13'(MAX_WIDTH)) begin
            r_w <= COORD_W'(MAX_WIDTH);
        end else begin
            r_w <= r_img_w;
        end
        if (r_img_h < COORD_W'(2)) begin
            r_h <= COORD_W'(2);
        end else if ({3'b0, r_img_h} > 13'(MAX_HEIGHT)) begin
            r_h <= COORD_W'(MAX_HEIGHT);
        end else begin
            r_h <= r_img_h;
        end
    end

    // Stage arithmetic
    always_comb begin
        n_tag.req = i_pix.action;
        n_tag.ok  = ({4'b0, i_pix.col} < 13'(MAX_WIDTH)) &&
                    ({4'b0, i_pix.row_pos} < 13'(MAX_HEIGHT));
        n_tag.x   = {1'b0, i_pix.col};
        n_tag.y   = {1'b0, i_pix.row_pos};
        n_tag.rgb = {i_pix.red_in, i_pix.green_in, i_pix.blue_in};
        n_xc  = $signed({2'b0, i_pix.col, 1'b0}) - $signed({2'b0, r_w});
        n_yc  = $signed({2'b0, i_pix.row_pos, 1'b0}) - $signed({2'b0, r_h});
        n_sqx = r_xc[0] * r_xc[0];
        n_sqy = r_yc[0] * r_yc[0];
        // r2 rounded from Q.42 to Q.28
        n_sum = {1'b0, r_phi, 20'b0} + {21'b0, r_plo} + 62'd8192;
        n_q   = n_sum[61:14];
        n_sq  = {1'b0, r_r2sq_f} + 61'd134217728;
        n_k1r = {r_t1[62], r_t1} + 64'd134217728;
        n_k2r = {r_t2[64], r_t2} + 66'd134217728;
        n_fac = 39'd268435456 + {{3{r_k1t8[35]}}, r_k1t8} + {r_k2t[37], r_k2t};
        // Source coordinate, Q.29 rounded to FRAC_BITS
        n_sx  = {r_mx[50], r_mx} + {14'b0, r_w, 28'b0} + 52'(64'd1 << (28 - FRAC_BITS));
        n_sy  = {r_my[50], r_my} + {14'b0, r_h, 28'b0} + 52'(64'd1 << (28 - FRAC_BITS));
        // Valid area check
        lim_x = {r_w - 1'b1, {FRAC_BITS{1'b0}}};
        lim_y = {r_h - 1'b1, {FRAC_BITS{1'b0}}};
        n_inside = !r_px[PXW-1] && (r_px[PXW-2:0] < (PXW-1)'(lim_x)) &&
                   !r_py[PXW-1] && (r_py[PXW-2:0] < (PXW-1)'(lim_y));
        n_job.req = r_tag[11].req;
        n_job.rgb = r_tag[11].rgb;
        if (r_tag[11].req == ACT_REQ) begin
            n_job.ok = n_inside;
            n_job.x  = r_px[FRAC_BITS +: COORD_W];
            n_job.y  = r_py[FRAC_BITS +: COORD_W];
        end else begin
            n_job.ok = r_tag[11].ok;
            n_job.x  = r_tag[11].x;
            n_job.y  = r_tag[11].y;
        end
        n_job.fx = FRAC_MAX'(r_px[FRAC_BITS-1:0]);
        n_job.fy = FRAC_MAX'(r_py[FRAC_BITS-1:0]);
    end

    // Valid shift line
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[NST-2:0], acc};
        end
    end

    // Payload pipeline, always advancing
    always_ff @(posedge i_clk) begin
        r_tag[0] <= n_tag;
        r_xc[0]  <= n_xc;
        r_yc[0]  <= n_yc;
        for (int k = 1; k < NST; k++) begin
            r_tag[k] <= r_tag[k-1];
        end
        for (int k = 1; k < 10; k++) begin
            r_xc[k] <= r_xc[k-1];
            r_yc[k] <= r_yc[k-1];
        end
        r_sqx    <= n_sqx[20:0];
        r_sqy    <= n_sqy[20:0];
        r_s      <= r_sqx + r_sqy;
        r_plo    <= r_s * r_inv[19:0];
        r_phi    <= r_s * r_inv[39:20];
        r_r2     <= (|n_q[47:30]) ? 30'h3FFF_FFFF : n_q[29:0];
        r_r2sq_f <= r_r2 * r_r2;
        r_t1     <= r_k1 * $signed({1'b0, r_r2});
        r_r2sq   <= n_sq[59:28];
        r_k1t    <= n_k1r[63:28];
        // k1 term waits two stages to line up with the k2 term
        r_k1t7   <= r_k1t;
        r_k1t8   <= r_k1t7;
        r_t2     <= r_k2 * $signed({1'b0, r_r2sq});
        r_k2t    <= n_k2r[65:28];
        r_fac    <= $signed(n_fac);
        r_mx     <= r_xc[9] * r_fac;
        r_my     <= r_yc[9] * r_fac;
        r_px     <= n_sx[51 : 29-FRAC_BITS];
        r_py     <= n_sy[51 : 29-FRAC_BITS];
        r_job    <= n_job;
    end

    assign o_push = r_vld[NST-1];
    assign o_job  = r_job;

endmodule

/* hdl/rud_queue.sv */
// Job queue between the front and back parts of the undistortion core.
// Small register-array FIFO; the front credit count keeps it from overflowing.
// Depends on rud_pkg.
`timescale 1ns / 1ps

module rud_queue import rud_pkg::*; #(
    parameter int DEPTH = DEF_QDEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_valid,
    output t_job o_job,
    input  logic i_pop
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wp, r_rp, n_wp, n_rp;
    logic [CW-1:0] r_cnt, n_cnt;

    // Pointer and count update
    always_comb begin
        n_wp  = (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
        n_rp  = (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wp <= n_wp;
            end
            if (i_pop) begin
                r_rp <= n_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rp];

endmodule

/* hdl/rud_back.sv */
// Back part: four-bank frame store, bilinear weighting and the output register.
// Stalls as a unit on the output handshake. Depends on rud_pkg, rud_if.
`timescale 1ns / 1ps

module rud_back import rud_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_job      i_job,
    output logic      o_pop,
    rud_out_if.source o_pix
);

    localparam int BXW = ($clog2(MAX_WIDTH) > 1) ? $clog2(MAX_WIDTH) - 1 : 1;
    localparam int BYW = ($clog2(MAX_HEIGHT) > 1) ? $clog2(MAX_HEIGHT) - 1 : 1;
    localparam int AW  = BXW + BYW;
    localparam int WW  = 2 * FRAC_BITS + 2;
    localparam int PRW = WW + CH_W;
    localparam int SMW = PRW + 2;
    localparam logic [FRAC_BITS:0] ONE_F = (FRAC_BITS + 1)'(1) << FRAC_BITS;

    logic en;
    logic rd_en, wr_en;
    logic [1:0] wsel;
    logic [AW-1:0] waddr;
    logic [FRAC_BITS-1:0] fx, fy;
    logic [FRAC_BITS:0]   gx, gy;

    logic [PIX_W-1:0] r_rd [4];
    logic             r0_vld, r0_ins, r0_sx, r0_sy;
    logic [WW-1:0]    r_w00, r_w10, r_w01, r_w11;
    logic             r1_vld, r1_ins;
    logic [PRW-1:0]   r_p [3][4];
    logic             r_ov, r_os;
    logic [CH_W-1:0]  r_oc [3];

    logic [PIX_W-1:0] lo0, lo1, hi0, hi1, c00, c10, c01, c11;
    logic [SMW-1:0]   sm [3];
    logic [SMW-2*FRAC_BITS-1:0] vq [3];
    logic [CH_W-1:0]  n_oc [3];

    assign en    = !r_ov || o_pix.ready;
    assign o_pop = i_valid && en;
    assign rd_en = o_pop && (i_job.req == ACT_REQ) && i_job.ok;
    assign wr_en = o_pop && (i_job.req == ACT_LOAD) && i_job.ok;
    assign wsel  = {i_job.y[0], i_job.x[0]};
    assign waddr = {BYW'({2'b0, i_job.y[COORD_W-1:1]}), BXW'({2'b0, i_job.x[COORD_W-1:1]})};

    // Frame store banks, one per parity of (x, y); the four neighbors hit distinct banks
    for (genvar b = 0; b < 4; b++) begin : g_bank
        localparam logic BX = 1'(b % 2);
        localparam logic BY = 1'(b / 2);
        logic [PIX_W-1:0]   mem [2**AW];
        logic [COORD_W-1:0] xs, ys;
        logic [AW-1:0]      raddr;

        assign xs    = (i_job.x[0] == BX) ? i_job.x : i_job.x + 1'b1;
        assign ys    = (i_job.y[0] == BY) ? i_job.y : i_job.y + 1'b1;
        assign raddr = {BYW'({2'b0, ys[COORD_W-1:1]}), BXW'({2'b0, xs[COORD_W-1:1]})};

        always_ff @(posedge i_clk) begin
            if (wr_en && (wsel == 2'(b))) begin
                mem[waddr] <= i_job.rgb;
            end
            if (en && rd_en) begin
                r_rd[b] <= mem[raddr];
            end
        end
    end

    // Bilinear weights
    always_comb begin
        fx = i_job.fx[FRAC_BITS-1:0];
        fy = i_job.fy[FRAC_BITS-1:0];
        gx = ONE_F - {1'b0, fx};
        gy = ONE_F - {1'b0, fy};
    end

    // Neighbor selection from bank outputs
    always_comb begin
        lo0 = r0_sy ? r_rd[2] : r_rd[0];
        lo1 = r0_sy ? r_rd[3] : r_rd[1];
        hi0 = r0_sy ? r_rd[0] : r_rd[2];
        hi1 = r0_sy ? r_rd[1] : r_rd[3];
        c00 = r0_sx ? lo1 : lo0;
        c10 = r0_sx ? lo0 : lo1;
        c01 = r0_sx ? hi1 : hi0;
        c11 = r0_sx ? hi0 : hi1;
    end

    // Weighted sum, round half up, clamp; zero when the source is outside the image
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            sm[c] = {2'b0, r_p[c][0]} + {2'b0, r_p[c][1]} + {2'b0, r_p[c][2]} +
                    {2'b0, r_p[c][3]} + SMW'(64'd1 << (2 * FRAC_BITS - 1));
            vq[c] = sm[c][SMW-1 : 2*FRAC_BITS];
            n_oc[c] = (vq[c] > (SMW-2*FRAC_BITS)'(255)) ? 8'hFF : vq[c][CH_W-1:0];
            if (!r1_ins) begin
                n_oc[c] = '0;
            end
        end
    end

    // Control stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
            r1_vld <= 1'b0;
            r_ov   <= 1'b0;
        end else if (en) begin
            r0_vld <= o_pop && (i_job.req == ACT_REQ);
            r1_vld <= r0_vld;
            r_ov   <= r1_vld;
        end
    end

    // Payload stages
    always_ff @(posedge i_clk) begin
        if (en) begin
            r0_ins <= i_job.ok;
            r0_sx  <= i_job.x[0];
            r0_sy  <= i_job.y[0];
            r_w00  <= gx * gy;
            r_w10  <= fx * gy;
            r_w01  <= gx * fy;
            r_w11  <= fx * fy;
            r1_ins <= r0_ins;
            for (int c = 0; c < 3; c++) begin
                r_p[c][0] <= c00[16-8*c +: CH_W] * r_w00;
                r_p[c][1] <= c10[16-8*c +: CH_W] * r_w10;
                r_p[c][2] <= c01[16-8*c +: CH_W] * r_w01;
                r_p[c][3] <= c11[16-8*c +: CH_W] * r_w11;
                r_oc[c]   <= n_oc[c];
            end
            r_os <= r1_ins;
        end
    end

    assign o_pix.valid     = r_ov;
    assign o_pix.red_out   = r_oc[0];
    assign o_pix.green_out = r_oc[1];
    assign o_pix.blue_out  = r_oc[2];
    assign o_pix.sampled   = r_os;

endmodule

/* hdl/radial_undistort_bilinear_core.sv */
// Radial lens-distortion correction core with bilinear sampling.
// Throughput: one transaction per cycle, loads and requests alike, while i_pix.ready is
// high and the output is not stalled. A result passes the 13-stage mapping pipeline,
// the queue write and three back stages.
// Reset: synchronous active low; clears control and config, frame store is not cleared.
// Depends on rud_pkg, rud_if, rud_front, rud_queue, rud_back.
`timescale 1ns / 1ps

module radial_undistort_bilinear_core import rud_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int FRAC_BITS  = DEF_FRAC_BITS,
    parameter int QDEPTH     = DEF_QDEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rud_in_if.sink    i_pix,
    rud_cfg_if.sink   i_cfg,
    rud_out_if.source o_pix
);

    logic push, pop, q_valid;
    t_job push_job, q_job;

    rud_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .FRAC_BITS  (FRAC_BITS),
        .QDEPTH     (QDEPTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (i_pix),
        .i_cfg   (i_cfg),
        .o_push  (push),
        .o_job   (push_job),
        .i_pop   (pop)
    );

    rud_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_valid (q_valid),
        .o_job   (q_job),
        .i_pop   (pop)
    );

    rud_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_job   (q_job),
        .o_pop   (pop),
        .o_pix   (o_pix)
    );

endmodule
